[sv/tklck_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tklck_pkg
// Types and constants shared by the top-k lowest cost keeper and its cells.
// ----------------------------------------------------------------------------
package tklck_pkg;

   // default depth of the kept list
   localparam int MaxKeptDefault = 16;

   // field widths
   localparam int CostW  = 24;
   localparam int StepW  = 16;
   localparam int TagW   = 16;
   localparam int RankW  = 4;
   localparam int LcntW  = 5;

   // request codes
   localparam logic REQ_STEP = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // saturation limit of the running total
   localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

   // input word
   typedef struct packed {
      logic             req_type;
      logic [StepW-1:0] step_cost;
      logic             last_step;
      logic [TagW-1:0]  solution_tag;
      logic [RankW-1:0] read_rank;
   } req_word_type;

   // result word
   typedef struct packed {
      logic             accepted;
      logic [LcntW-1:0] list_count;
      logic             entry_valid;
      logic [CostW-1:0] entry_cost;
      logic [TagW-1:0]  entry_tag;
   } rsp_word_type;

   // one kept entry, also what a cell hands to its neighbor
   typedef struct packed {
      logic [CostW-1:0] cost;
      logic [TagW-1:0]  tag;
   } entry_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic      ins_en;
      entry_type new_entry;
   } chain_ctl_type;

endpackage
`default_nettype wire

[sv/tklck_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tklck_cell
// One rank of the sorted list: holds an entry, keeps it, takes the new entry,
// or takes its upper neighbor's entry when an insertion shifts the list down.
// ----------------------------------------------------------------------------
module tklck_cell (
   input  wire                     clock,
   input  tklck_pkg::chain_ctl_type ctl,
   input  wire                     occupied,
   input  wire                     prev_keep,
   input  tklck_pkg::entry_type    prev_entry,
   output tklck_pkg::entry_type    entry,
   output logic                    keep
);

   tklck_pkg::entry_type entry_ff;
   tklck_pkg::entry_type entry_in;

   // entry stays where it is when it is not dearer than the new total
   assign keep  = occupied && (entry_ff.cost <= ctl.new_entry.cost);
   assign entry = entry_ff;

   // keep, take the new entry, or take the neighbor's entry
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en && !keep) begin
         if (prev_keep) begin
            entry_in = ctl.new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

[sv/top_k_lowest_cost_keeper.sv]
`timescale 1ns / 1ps
`default_nettype none
// result: the word is registered and shows in the cycle after start, on rsp_strobe for one cycle
// throughput: one word per cycle; busy stays low, every cell compares and shifts
//   in the same cycle through the neighbor-to-neighbor chain
// reset: list count and running total go to zero; cell contents stay unknown
//   and are never read until written; the receiver cannot stall
// ----------------------------------------------------------------------------
// top_k_lowest_cost_keeper
// Keeps the MAX_KEPT cheapest finished solutions in a sorted chain of cells.
// ----------------------------------------------------------------------------
module top_k_lowest_cost_keeper #(
   parameter int MAX_KEPT = tklck_pkg::MaxKeptDefault
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  tklck_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output tklck_pkg::rsp_word_type rsp_word
);

   localparam int CountW = $clog2(MAX_KEPT + 1);
   localparam int ReadN  = (MAX_KEPT < 16) ? MAX_KEPT : 16;
   localparam int CmpW   = (CountW > tklck_pkg::RankW) ? CountW : tklck_pkg::RankW;

   logic [CountW-1:0]          count_ff, count_in;
   logic [tklck_pkg::CostW-1:0] total_ff, total_in;
   logic                       strobe_ff;
   tklck_pkg::rsp_word_type    rsp_ff, rsp_in;

   logic                       accept;
   logic                       is_step;
   logic                       do_insert;
   logic [tklck_pkg::CostW:0]  sum;
   logic [tklck_pkg::CostW-1:0] sat_total;
   logic                       full;
   logic                       took;
   tklck_pkg::chain_ctl_type   ctl;

   tklck_pkg::entry_type       cell_entry [MAX_KEPT];
   logic [MAX_KEPT-1:0]        cell_keep;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign is_step = (req_word.req_type == tklck_pkg::REQ_STEP);

   // saturating running total
   assign sum       = {1'b0, total_ff} + {{(tklck_pkg::CostW - tklck_pkg::StepW + 1){1'b0}},
                                          req_word.step_cost};
   assign sat_total = sum[tklck_pkg::CostW] ? tklck_pkg::CostMax
                                            : sum[tklck_pkg::CostW-1:0];

   assign do_insert = accept && is_step && req_word.last_step;
   assign full      = (count_ff == CountW'(MAX_KEPT));
   // dropped only when the list is full and every entry stays put
   assign took      = !(full && cell_keep[MAX_KEPT-1]);

   assign ctl.ins_en         = do_insert && took;
   assign ctl.new_entry.cost = sat_total;
   assign ctl.new_entry.tag  = req_word.solution_tag;

   // chain of cells, rank 0 first
   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      if (i == 0) begin : g_head
         tklck_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (count_ff != '0),
            .prev_keep  (1'b1),
            .prev_entry (ctl.new_entry),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
         );
      end else begin : g_body
         tklck_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (CountW'(i) < count_ff),
            .prev_keep  (cell_keep[i-1]),
            .prev_entry (cell_entry[i-1]),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
         );
      end
   end

   // next count and running total
   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      if (accept && is_step) begin
         total_in = req_word.last_step ? '0 : sat_total;
         if (req_word.last_step && !full) begin
            count_in = count_ff + CountW'(1);
         end
      end
   end

   // result word: read mux over the ranks the rank field reaches
   always_comb begin
      rsp_in            = '0;
      rsp_in.list_count = tklck_pkg::LcntW'(count_in);
      if (is_step) begin
         rsp_in.accepted = req_word.last_step && took;
      end else if (CmpW'(req_word.read_rank) < CmpW'(count_ff)) begin
         rsp_in.entry_valid = 1'b1;
         for (int k = 0; k < ReadN; k++) begin
            if (req_word.read_rank == tklck_pkg::RankW'(k)) begin
               rsp_in.entry_cost = cell_entry[k].cost;
               rsp_in.entry_tag  = cell_entry[k].tag;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         total_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         total_ff  <= total_in;
         strobe_ff <= accept;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   // count never passes the list depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MAX_KEPT))
      else $error("list count above depth");

   // a strobe answers a word taken in the previous cycle
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("strobe without a word");

   // an accepted solution leaves a nonempty list
   a_accept_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.accepted) |-> (count_ff != '0))
      else $error("accepted with empty list");

   // count moves only on a finished step word
   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(do_insert) && !$past(reset)))
      else $error("count changed without insertion");

endmodule
`default_nettype wire

[bench/top_k_lowest_cost_keeper_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_lowest_cost_keeper_test
// Self-checking bench for the lowest cost keeper. Step words build up solution
// totals, and read words fetch ranked entries. A scoreboard keeps its own
// sorted list and predicts every result word, which is checked field by
// field. Directed words come first, then random solutions, reads and noise
// with idle bursts on the sender.
// ----------------------------------------------------------------------------
module top_k_lowest_cost_keeper_test;

   localparam int ListDepth   = tklck_pkg::MaxKeptDefault;
   localparam int CostW       = tklck_pkg::CostW;
   localparam int StepW       = tklck_pkg::StepW;
   localparam int TagW        = tklck_pkg::TagW;
   localparam int RankW       = tklck_pkg::RankW;
   localparam int LcntW       = tklck_pkg::LcntW;
   localparam int RandomItems = 730;
   localparam int CalmTail    = 120;
   localparam int HeavySteps  = 260;
   localparam int CycleLimit  = 100000;
   localparam int ReportLimit = 10;

   // sorted list predictor plus the queue of result words still due
   class cost_list_scoreboard;
      logic [CostW-1:0]       kept_cost [ListDepth];
      logic [TagW-1:0]        kept_tag  [ListDepth];
      int                     kept_n;
      logic [CostW-1:0]       partial_total;
      tklck_pkg::rsp_word_type due_words [$];
      int                     mismatches;

      function new();
         kept_n        = 0;
         partial_total = '0;
         mismatches    = 0;
      endfunction

      // place a finished total after all entries of equal or lower cost
      function bit insert_solution(logic [CostW-1:0] total, logic [TagW-1:0] tag);
         int slot;
         int tail_pos;
         slot = 0;
         while (slot < kept_n && kept_cost[slot] <= total) slot++;
         if (kept_n >= ListDepth && slot >= kept_n) return 1'b0;
         tail_pos = (kept_n < ListDepth) ? kept_n : ListDepth - 1;
         for (int i = tail_pos; i > slot; i--) begin
            kept_cost[i] = kept_cost[i-1];
            kept_tag[i]  = kept_tag[i-1];
         end
         kept_cost[slot] = total;
         kept_tag[slot]  = tag;
         if (kept_n < ListDepth) kept_n++;
         return 1'b1;
      endfunction

      // work out the result word of one accepted input word
      function void note_word(tklck_pkg::req_word_type w);
         tklck_pkg::rsp_word_type due;
         logic [CostW:0] sum;
         due = '0;
         if (w.req_type == tklck_pkg::REQ_STEP) begin
            sum           = {1'b0, partial_total} + (CostW + 1)'(w.step_cost);
            partial_total = (sum > (CostW + 1)'(tklck_pkg::CostMax)) ? tklck_pkg::CostMax
                                                                    : sum[CostW-1:0];
            if (w.last_step) begin
               due.accepted  = insert_solution(partial_total, w.solution_tag);
               partial_total = '0;
            end
         end else if (w.read_rank < kept_n) begin
            due.entry_valid = 1'b1;
            due.entry_cost  = kept_cost[w.read_rank];
            due.entry_tag   = kept_tag[w.read_rank];
         end
         due.list_count = LcntW'(kept_n);
         due_words = {due_words, due};
      endfunction

      function void flag_field(string field, logic [CostW-1:0] want,
                               logic [CostW-1:0] seen);
         if (seen !== want) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("%0t mismatch on %s: expected %0h, got %0h",
                        $realtime, field, want, seen);
         end
      endfunction

      // compare one result word against the oldest prediction
      function void check_word(tklck_pkg::rsp_word_type got);
         tklck_pkg::rsp_word_type due;
         if (due_words.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("%0t result word with nothing outstanding: %0h", $realtime, got);
            return;
         end
         due = due_words.pop_front();
         flag_field("accepted", CostW'(due.accepted), CostW'(got.accepted));
         flag_field("list_count", CostW'(due.list_count), CostW'(got.list_count));
         flag_field("entry_valid", CostW'(due.entry_valid), CostW'(got.entry_valid));
         flag_field("entry_cost", due.entry_cost, got.entry_cost);
         flag_field("entry_tag", CostW'(due.entry_tag), CostW'(got.entry_tag));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   tklck_pkg::req_word_type req_word = '0;
   logic                    rsp_strobe;
   tklck_pkg::rsp_word_type rsp_word;

   cost_list_scoreboard sb = new();
   int  items_sent = 0;
   bit  calm       = 1'b0;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   top_k_lowest_cost_keeper DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // sample results and accepted words on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) sb.check_word(rsp_word);
         if (start && !busy) sb.note_word(req_word);
      end
   end

   function automatic tklck_pkg::req_word_type step_word(logic [StepW-1:0] cost,
                                                         logic last,
                                                         logic [TagW-1:0] tag);
      tklck_pkg::req_word_type w;
      w.req_type     = tklck_pkg::REQ_STEP;
      w.step_cost    = cost;
      w.last_step    = last;
      w.solution_tag = tag;
      w.read_rank    = RankW'($urandom_range(0, 15));
      return w;
   endfunction

   function automatic tklck_pkg::req_word_type read_word(logic [RankW-1:0] rank);
      tklck_pkg::req_word_type w;
      w.req_type     = tklck_pkg::REQ_READ;
      w.step_cost    = StepW'($urandom);
      w.last_step    = 1'($urandom);
      w.solution_tag = TagW'($urandom);
      w.read_rank    = rank;
      return w;
   endfunction

   // present one word from the falling edge, with an optional idle burst first
   task automatic issue_word(input tklck_pkg::req_word_type w);
      int gap;
      gap = (!calm && (items_sent / 40) % 3 != 2 && $urandom_range(0, 3) == 0)
            ? $urandom_range(1, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start    <= 1'b0;
         req_word <= tklck_pkg::req_word_type'({$urandom, $urandom});
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // one well-formed solution of random length and cost
   task automatic issue_solution(input int steps, input bit wide);
      logic [StepW-1:0] cost;
      for (int i = 0; i < steps; i++) begin
         cost = wide ? StepW'($urandom) : StepW'($urandom_range(0, 12));
         issue_word(step_word(cost, i == steps - 1, TagW'($urandom)));
      end
   endtask

   task automatic run_directed();
      // reads of an empty list, junk in the ignored fields
      issue_word(read_word(4'd0));
      issue_word('{tklck_pkg::REQ_READ, 16'hFFFF, 1'b1, 16'hFFFF, 4'd15});
      // extremes of a single-step solution, then a two-step solution
      issue_word(step_word(16'hFFFF, 1'b1, 16'hFFFF));
      issue_word(step_word(16'd5, 1'b0, 16'hAAAA));
      issue_word(step_word(16'd5, 1'b1, 16'h0001));
      // equal cost goes behind the earlier ones
      issue_word(step_word(16'd10, 1'b1, 16'h0002));
      issue_word(step_word(16'd0, 1'b1, 16'h0000));
      issue_word(step_word(16'd10, 1'b1, 16'h5555));
      for (int r = 0; r < 6; r++) issue_word(read_word(RankW'(r)));
      issue_word(read_word(4'd15));
   endtask

   task automatic run_random();
      int  roll;
      bit  heavy_done;
      heavy_done = 1'b0;
      while (items_sent < RandomItems) begin
         calm = (items_sent >= RandomItems - CalmTail);
         roll = $urandom_range(0, 99);
         if (!heavy_done && items_sent >= 250) begin
            // long expensive solution drives the total into saturation
            for (int i = 0; i < HeavySteps; i++)
               issue_word(step_word(16'hFFFF, i == HeavySteps - 1, TagW'($urandom)));
            heavy_done = 1'b1;
         end else if (roll < 30) begin
            issue_word(read_word(RankW'($urandom_range(0, 15))));
         end else if (roll < 36) begin
            issue_word(step_word(StepW'($urandom), 1'($urandom), TagW'($urandom)));
         end else begin
            issue_solution($urandom_range(1, 4), $urandom_range(0, 4) == 0);
         end
      end
   endtask

   // watchdog
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // main sequence
   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      start <= 1'b0;
      while (sb.due_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
